[sv/mspd_pkg.sv]
// shared types, codes and helper functions of the packet deframer
`timescale 1ns / 1ps

package mspd_pkg;

  // tag of a result beat
  typedef enum logic [1:0] {
    KIND_ADDR    = 2'd0,
    KIND_CMD     = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  // end-of-packet status
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_LEN_ERR = 2'd2
  } status_e;

  localparam logic [7:0]  MAGIC [4] = '{8'hDB, 8'h8B, 8'hAF, 8'hD5};
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] MIN_SIZE  = 16'd4;
  localparam logic [15:0] INV_CHECK = 16'hFFFF;

  // registered input beat
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
    logic       resync;
  } beat_t;

  // result of one processed beat, before the output register
  typedef struct packed {
    logic       vld;
    kind_e      kind;
    logic [7:0] value;
    status_e    status;
    logic       last;
  } result_t;

  // one step of the magic hunt; a result of four means the magic is complete
  function automatic logic [2:0] hunt_step(logic [2:0] cnt, logic [7:0] b);
    logic [2:0] nxt;
    nxt = 3'd0;
    if (b == MAGIC[cnt[1:0]]) begin
      nxt = cnt + 3'd1;
    end
    return nxt;
  endfunction

  // crc-16 byte update, msb first, unrolled over the eight bits
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int j = 0; j < 8; j++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[sv/mspd_in_reg.sv]
// input register stage of the packet deframer
`timescale 1ns / 1ps

module mspd_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [7:0]     data_byte_i,
  input  logic           resync_i,
  input  logic           advance_i,
  output mspd_pkg::beat_t beat_o
);
  import mspd_pkg::*;

  logic       vld_q;
  logic [7:0] data_q;
  logic       resync_q;
  logic       take;

  assign in_stall_o = vld_q && !advance_i;
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (take) begin
      vld_q <= 1'b1;
    end else if (advance_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q   <= data_byte_i;
      resync_q <= resync_i;
    end
  end

  assign beat_o = '{vld: vld_q, data: data_q, resync: resync_q};

endmodule

[sv/mspd_frame_ctl.sv]
// framing state machine, header checks and crc of the packet deframer
`timescale 1ns / 1ps

module mspd_frame_ctl #(
  parameter int MAX_ADDRESS_BYTES = 9
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mspd_pkg::beat_t   beat_i,
  input  logic              advance_i,
  output mspd_pkg::result_t res_o
);
  import mspd_pkg::*;

  localparam int ACW = $clog2(MAX_ADDRESS_BYTES + 1);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_SIZE = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    SEC_ADDR    = 2'd0,
    SEC_CMD     = 2'd1,
    SEC_PAYLOAD = 2'd2
  } section_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  hcnt_q, hcnt_d;
  logic [7:0]  size_q [3];
  logic [7:0]  size_d [3];
  logic [15:0] bsize_q, bsize_d;
  logic [15:0] pos_q, pos_d;
  logic [ACW-1:0] acnt_q, acnt_d;
  section_e    sec_q, sec_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rcrc_q, rcrc_d;
  logic        cmd_seen_q, cmd_seen_d;

  logic [7:0]  b;
  logic [15:0] sz;
  logic [15:0] inv;
  logic [2:0]  hunt_nxt;
  logic [2:0]  rescan;
  logic [16:0] pos_ext;
  logic [16:0] size_ext;
  logic [ACW-1:0] acnt_inc;

  assign b        = beat_i.data;
  assign sz       = {size_q[0], size_q[1]};
  assign inv      = {size_q[2], b};
  assign hunt_nxt = hunt_step({1'b0, hcnt_q}, b);
  assign rescan   = hunt_step(hunt_step(hunt_step(hunt_step(3'd0, size_q[0]),
                      size_q[1]), size_q[2]), b);
  assign pos_ext  = {1'b0, pos_q};
  assign size_ext = {1'b0, bsize_q};
  assign acnt_inc = acnt_q + ACW'(1);

  always_comb begin
    phase_d    = phase_q;
    hcnt_d     = hcnt_q;
    size_d     = size_q;
    bsize_d    = bsize_q;
    pos_d      = pos_q;
    acnt_d     = acnt_q;
    sec_d      = sec_q;
    crc_d      = crc_q;
    rcrc_d     = rcrc_q;
    cmd_seen_d = cmd_seen_q;
    res_o      = '{vld: 1'b0, kind: KIND_ADDR, value: b, status: ST_OK, last: 1'b0};

    if (beat_i.resync) begin
      phase_d = PH_HUNT;
      hcnt_d  = 2'd0;
    end else begin
      unique case (phase_q)
        PH_SIZE: begin
          if (hcnt_q != 2'd3) begin
            size_d[hcnt_q] = b;
            hcnt_d         = hcnt_q + 2'd1;
          end else if (((sz ^ inv) != INV_CHECK) || (sz < MIN_SIZE)) begin
            // bad size: the four size bytes go back through the hunt
            if (rescan[2]) begin
              phase_d = PH_SIZE;
              hcnt_d  = 2'd0;
            end else begin
              phase_d = PH_HUNT;
              hcnt_d  = rescan[1:0];
            end
          end else begin
            phase_d    = PH_BODY;
            hcnt_d     = 2'd0;
            bsize_d    = sz;
            pos_d      = 16'd0;
            acnt_d     = '0;
            sec_d      = SEC_ADDR;
            crc_d      = CRC_INIT;
            rcrc_d     = 16'd0;
            cmd_seen_d = 1'b0;
          end
        end
        PH_BODY: begin
          pos_d = pos_q + 16'd1;
          if (pos_ext + 17'd2 < size_ext) begin
            crc_d     = crc_byte(crc_q, b);
            res_o.vld = 1'b1;
            unique case (sec_q)
              SEC_ADDR: begin
                res_o.kind = KIND_ADDR;
                acnt_d     = acnt_inc;
                if (!b[7] || (acnt_inc >= ACW'(MAX_ADDRESS_BYTES))) begin
                  sec_d = SEC_CMD;
                end
              end
              SEC_CMD: begin
                res_o.kind = KIND_CMD;
                cmd_seen_d = 1'b1;
                sec_d      = SEC_PAYLOAD;
              end
              default: begin
                res_o.kind = KIND_PAYLOAD;
              end
            endcase
          end else begin
            rcrc_d = {rcrc_q[7:0], b};
            if (pos_ext + 17'd1 >= size_ext) begin
              res_o.vld   = 1'b1;
              res_o.kind  = KIND_END;
              res_o.value = 8'd0;
              res_o.last  = 1'b1;
              if (rcrc_d != crc_q) begin
                res_o.status = ST_CRC_ERR;
              end else if (!cmd_seen_q) begin
                res_o.status = ST_LEN_ERR;
              end else begin
                res_o.status = ST_OK;
              end
              phase_d = PH_HUNT;
              hcnt_d  = 2'd0;
            end
          end
        end
        default: begin
          // hunting magic, also any unused phase code
          if (hunt_nxt[2]) begin
            phase_d = PH_SIZE;
            hcnt_d  = 2'd0;
          end else begin
            phase_d = PH_HUNT;
            hcnt_d  = hunt_nxt[1:0];
          end
        end
      endcase
    end

    if (!beat_i.vld) begin
      res_o.vld = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      hcnt_q     <= 2'd0;
      bsize_q    <= 16'd0;
      pos_q      <= 16'd0;
      acnt_q     <= '0;
      sec_q      <= SEC_ADDR;
      crc_q      <= CRC_INIT;
      rcrc_q     <= 16'd0;
      cmd_seen_q <= 1'b0;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      hcnt_q     <= hcnt_d;
      bsize_q    <= bsize_d;
      pos_q      <= pos_d;
      acnt_q     <= acnt_d;
      sec_q      <= sec_d;
      crc_q      <= crc_d;
      rcrc_q     <= rcrc_d;
      cmd_seen_q <= cmd_seen_d;
    end
  end

  // size bytes are always written before they are read
  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      size_q <= size_d;
    end
  end

endmodule

[sv/magic_sync_packet_deframer_crc16_unit.sv]
// top level of the magic-sync packet deframer with crc-16 check
`timescale 1ns / 1ps

// accepted beats go through the input register, then the result register
// throughput: one beat per cycle unless the output stalls, set by the registers
// each beat gives zero or one result beat; stall only backs up from the output
// reset (async, active low) empties both registers and starts the magic hunt
// with a fresh crc

module magic_sync_packet_deframer_crc16_unit #(
  parameter int MAX_ADDRESS_BYTES = 9
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       resync_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] byte_value_o,
  output logic [1:0] status_o,
  output logic       last_o
);
  import mspd_pkg::*;

  beat_t   beat;
  result_t res;
  logic    advance;

  // result register
  logic       out_vld_q;
  kind_e      kind_q;
  logic [7:0] value_q;
  status_e    status_q;
  logic       last_q;

  // the registered beat moves on whenever the result register is free
  // or is being emptied this cycle
  assign advance = beat.vld && (!out_vld_q || !out_stall_i);

  mspd_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .resync_i    (resync_i),
    .advance_i   (advance),
    .beat_o      (beat)
  );

  mspd_frame_ctl #(
    .MAX_ADDRESS_BYTES (MAX_ADDRESS_BYTES)
  ) u_frame_ctl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .advance_i (advance),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= res.vld;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  // payload only loads on advance, so it holds while stalled
  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q   <= res.kind;
      value_q  <= res.value;
      status_q <= res.status;
      last_q   <= res.last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign kind_o       = kind_q;
  assign byte_value_o = value_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

  // the input only backs up behind a blocked result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while result register could move");

  // last marks exactly the end beat
  a_last_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (kind_o == KIND_END)))
    else $error("last flag disagrees with end kind");

  // body beats carry ok status, end beats carry no byte
  a_body_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (status_o == ST_OK))
    else $error("status set on a body beat");

  a_end_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (byte_value_o == 8'd0 &&
      (status_o == ST_OK || status_o == ST_CRC_ERR || status_o == ST_LEN_ERR)))
    else $error("malformed end beat");

endmodule
